[design/kvbs_pkg.sv]
// Shared types, constants and a helper function of the kernel version banner scanner.
package kvbs_pkg;

  // Length of the banner prefix and number of dotted fields kept.
  localparam int unsigned PrefixLen = 14;
  localparam int unsigned NumFields = 3;

  // Character codes used by the scanner.
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChCapL = 8'h4C;

  // Configuration register indexes.
  localparam logic [1:0] CfgBufferLength   = 2'd0;
  localparam logic [1:0] CfgThresholdMajor = 2'd1;
  localparam logic [1:0] CfgThresholdMinor = 2'd2;
  localparam logic [1:0] CfgThresholdPatch = 2'd3;

  // Scan phase of the current image.
  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhParse  = 2'd1,
    PhDone   = 2'd2
  } phase_e;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result.
  typedef struct packed {
    logic        found;
    logic [15:0] major_number;
    logic [15:0] minor_number;
    logic [15:0] patch_number;
    logic        is_older;
  } out_t;

  // Configuration as seen by the scan core.
  typedef struct packed {
    logic [31:0] match_limit;
    logic [15:0] thr_major;
    logic [15:0] thr_minor;
    logic [15:0] thr_patch;
  } cfg_t;

  // Characters of the "Linux version " prefix by position.
  function automatic logic [7:0] banner_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h4C; // L
      4'd1:    ch = 8'h69; // i
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h75; // u
      4'd4:    ch = 8'h78; // x
      4'd5:    ch = 8'h20; // space
      4'd6:    ch = 8'h76; // v
      4'd7:    ch = 8'h65; // e
      4'd8:    ch = 8'h72; // r
      4'd9:    ch = 8'h73; // s
      4'd10:   ch = 8'h69; // i
      4'd11:   ch = 8'h6F; // o
      4'd12:   ch = 8'h6E; // n
      4'd13:   ch = 8'h20; // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[design/kvbs_cfg_regs.sv]
// Configuration registers of the banner scanner, with the match window limit precomputed.
module kvbs_cfg_regs #(
  parameter int unsigned TAIL_EXCLUDE = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i,
  output kvbs_pkg::cfg_t  cfg_o
);
  import kvbs_pkg::*;

  localparam logic [31:0] TailWindow = 32'(TAIL_EXCLUDE);

  logic [31:0] limit_q, limit_d;
  logic [15:0] thr_major_q, thr_minor_q, thr_patch_q;
  logic [31:0] tail_len;

  // The first version digit must lie at or before the limit: limit = length - min(length, tail).
  always_comb begin
    tail_len = (cfg_wdata_i < TailWindow) ? cfg_wdata_i : TailWindow;
    limit_d  = cfg_wdata_i - tail_len;
  end

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      thr_major_q <= '0;
      thr_minor_q <= '0;
      thr_patch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBufferLength:   limit_q     <= limit_d;
        CfgThresholdMajor: thr_major_q <= cfg_wdata_i[15:0];
        CfgThresholdMinor: thr_minor_q <= cfg_wdata_i[15:0];
        CfgThresholdPatch: thr_patch_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{match_limit: limit_q, thr_major: thr_major_q,
                   thr_minor: thr_minor_q, thr_patch: thr_patch_q};

  // The window limit never exceeds the written length.
  a_limit_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CfgBufferLength) |=> (limit_q <= $past(cfg_wdata_i)))
    else $error("window limit larger than buffer length");

  // A major threshold write lands in its register and leaves the window limit unchanged.
  a_major_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CfgThresholdMajor) |=>
      (thr_major_q == $past(cfg_wdata_i[15:0]) && $stable(limit_q)))
    else $error("major threshold write misrouted");

  // Without a write the window limit and the patch threshold hold.
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> ($stable(limit_q) && $stable(thr_patch_q)))
    else $error("configuration changed without a write");

endmodule

[design/kvbs_scan_core.sv]
// Per-byte scan state: prefix matching, version field parsing and result forming.
module kvbs_scan_core #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  kvbs_pkg::in_t   item_i,
  input  kvbs_pkg::cfg_t  cfg_i,
  output logic            emit_o,
  output kvbs_pkg::out_t  res_o
);
  import kvbs_pkg::*;

  localparam int unsigned CmpWidth = (FIELD_WIDTH > 16) ? FIELD_WIDTH : 16;
  localparam logic [FIELD_WIDTH-1:0] FieldMax = '1;
  localparam logic [3:0] PrefixLenW = 4'(PrefixLen);

  logic [31:0]            pos_q, pos_d;
  logic [3:0]             pm_q, pm_d;
  phase_e                 phase_q, phase_d;
  logic [1:0]             fidx_q, fidx_d;
  logic [FIELD_WIDTH-1:0] fld_q [NumFields];
  logic [FIELD_WIDTH-1:0] fld_d [NumFields];
  logic [FIELD_WIDTH-1:0] fld_p [NumFields];

  logic                   is_digit;
  logic [3:0]             digit;
  logic                   emit;
  logic                   found;
  logic                   older;
  logic [CmpWidth-1:0]    v_ext [NumFields];
  logic [CmpWidth-1:0]    t_ext [NumFields];

  // Decimal accumulate with saturation at the field maximum.
  function automatic logic [FIELD_WIDTH-1:0] acc_digit(input logic [FIELD_WIDTH-1:0] v,
                                                       input logic [3:0] d);
    logic [FIELD_WIDTH+3:0] s;
    s = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (FIELD_WIDTH+4)'(d);
    return (s[FIELD_WIDTH+3:FIELD_WIDTH] != '0) ? FieldMax : s[FIELD_WIDTH-1:0];
  endfunction

  assign is_digit = (item_i.data_byte >= ChZero) && (item_i.data_byte <= ChNine);
  assign digit    = 4'(item_i.data_byte - ChZero);

  // Next state for one byte.
  always_comb begin
    pos_d   = pos_q;
    pm_d    = pm_q;
    phase_d = phase_q;
    fidx_d  = fidx_q;
    fld_d   = fld_q;
    emit    = 1'b0;
    found   = 1'b0;

    unique case (phase_q)
      PhSearch: begin
        if (pm_q == PrefixLenW && is_digit && pos_q <= cfg_i.match_limit) begin
          phase_d = PhParse;
          fidx_d  = '0;
          fld_d[0] = acc_digit('0, digit);
          fld_d[1] = '0;
          fld_d[2] = '0;
        end else if (pm_q < PrefixLenW && item_i.data_byte == banner_char(pm_q)) begin
          pm_d = pm_q + 4'd1;
        end else begin
          pm_d = (item_i.data_byte == ChCapL) ? 4'd1 : 4'd0;
        end
      end
      PhParse: begin
        if (is_digit) begin
          for (int k = 0; k < NumFields; k++) begin
            if (fidx_q == 2'(k)) fld_d[k] = acc_digit(fld_q[k], digit);
          end
        end else if (item_i.data_byte == ChDot) begin
          if (fidx_q < 2'(NumFields)) fidx_d = fidx_q + 2'd1;
        end else begin
          emit    = 1'b1;
          found   = 1'b1;
          phase_d = PhDone;
        end
      end
      default: ;
    endcase

    // End of image while still searching or parsing.
    if (item_i.last_byte && !emit && (phase_d == PhSearch || phase_d == PhParse)) begin
      emit    = 1'b1;
      found   = (phase_d == PhParse);
      phase_d = PhDone;
    end

    if (pos_q != '1) pos_d = pos_q + 32'd1;

    // Fields as parsed, kept for the result before a rearm clears them.
    fld_p = fld_d;

    // The last byte rearms the scanner.
    if (item_i.last_byte) begin
      pos_d   = '0;
      pm_d    = '0;
      phase_d = PhSearch;
      fidx_d  = '0;
      for (int k = 0; k < NumFields; k++) fld_d[k] = '0;
    end
  end

  // Lexicographic compare of the parsed version against the threshold.
  always_comb begin
    for (int k = 0; k < NumFields; k++) v_ext[k] = CmpWidth'(fld_p[k]);
    t_ext[0] = CmpWidth'(cfg_i.thr_major);
    t_ext[1] = CmpWidth'(cfg_i.thr_minor);
    t_ext[2] = CmpWidth'(cfg_i.thr_patch);
    if (v_ext[0] != t_ext[0])      older = (v_ext[0] < t_ext[0]);
    else if (v_ext[1] != t_ext[1]) older = (v_ext[1] < t_ext[1]);
    else                           older = (v_ext[2] < t_ext[2]);
  end

  // Result fields; a miss reports all zeros.
  always_comb begin
    res_o = '0;
    if (found) begin
      res_o.found        = 1'b1;
      res_o.major_number = 16'(fld_p[0]);
      res_o.minor_number = 16'(fld_p[1]);
      res_o.patch_number = 16'(fld_p[2]);
      res_o.is_older     = older;
    end
  end

  assign emit_o = emit;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pm_q    <= '0;
      phase_q <= PhSearch;
      fidx_q  <= '0;
      for (int k = 0; k < NumFields; k++) fld_q[k] <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      pm_q    <= pm_d;
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      fld_q   <= fld_d;
    end
  end

  // The prefix count never runs past the prefix length.
  a_pm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_q <= PrefixLenW)
    else $error("prefix count out of range");

  // Leaving the search phase requires a complete prefix.
  a_parse_needs_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhSearch) |-> (pm_q == PrefixLenW))
    else $error("parsing without a matched prefix");

  // Field values stay clear while searching.
  a_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSearch) |-> (fld_q[0] == '0 && fld_q[1] == '0 && fld_q[2] == '0))
    else $error("stale field value while searching");

  // A stepped last byte always returns the scanner to the search phase.
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last_byte) |=> (phase_q == PhSearch && pos_q == '0))
    else $error("last byte did not rearm");

endmodule

[design/kernel_version_banner_scanner.sv]
// Top level of the kernel version banner scanner: input register, scan core and result register.
// The result register loads when the byte that causes the result, held in the input register, steps the scan core.
// Throughput: one byte per cycle while no stall is raised; the single scan core state update sets that figure.
// A byte stalls only when it produces a result while the result register is still held.
// Reset (rst_ni low, asynchronous) clears the scan state, the configuration and both valid
// flags; the payload registers are not reset.
module kernel_version_banner_scanner #(
  parameter int unsigned FIELD_WIDTH  = 16,
  parameter int unsigned TAIL_EXCLUDE = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kvbs_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kvbs_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i
);
  import kvbs_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_vld_q, in_vld_d;
  out_t out_q;
  logic out_vld_q, out_vld_d;
  logic step;
  logic emit;
  out_t res;
  logic in_accept;

  kvbs_cfg_regs #(
    .TAIL_EXCLUDE(TAIL_EXCLUDE)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  kvbs_scan_core #(
    .FIELD_WIDTH(FIELD_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .cfg_i (cfg),
    .emit_o(emit),
    .res_o (res)
  );

  // The held byte advances unless it has a result and the result register cannot take it.
  assign step       = in_vld_q && !(emit && out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Valid flags of both registers.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept)  in_vld_d = 1'b1;
    else if (step)  in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    if (step && emit)                   out_vld_d = 1'b1;
    else if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept)    in_q  <= in_data_i;
    if (step && emit) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A result is never written over one that is still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit) |-> !(out_vld_q && out_stall_i))
    else $error("result register overwritten");

  // Input stalls only while a byte is held.
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("stall without a held byte");

  // A miss carries no version and is never older.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |-> (!out_q.is_older && out_q.major_number == '0))
    else $error("miss result with nonzero fields");

endmodule
